// ----- src/rbl_pkg.sv -----
// Package: shared widths, constants, colour tables, state and control types of the bar meter.
`default_nettype none

package rbl_pkg;

   localparam int BAR_COUNT           = 64;
   localparam int BAR_W               = $clog2(BAR_COUNT + 1);
   localparam int NUM_W               = 6;
   localparam int COLOR_COUNT         = 64;
   localparam int COLOR_W             = 8;
   localparam int MAX_SAMPLES_PER_BAR = 1024;
   localparam int CNT_W               = 11;
   localparam int SAMPLE_W            = 16;
   localparam int SQ_W                = 31;
   localparam int SUM_W               = 40;
   localparam int SCALED_W            = SUM_W + 6;
   localparam int DVD_W               = SUM_W + 2;
   localparam int QUO_W               = 32;
   localparam int ROOT_W              = 16;
   localparam int REM_W               = ROOT_W + 1;
   localparam int UNIT_W              = REM_W + 2;
   localparam int STEP_W              = 5;
   localparam int DIV_STEPS           = QUO_W;
   localparam int ROOT_STEPS          = ROOT_W;
   localparam int HEIGHT_W            = 15;

   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 15'd29491;

   localparam logic [COLOR_W-1:0] GREEN_TAB [COLOR_COUNT] = '{
      8'd243, 8'd238, 8'd231, 8'd223, 8'd214, 8'd205, 8'd194, 8'd183,
      8'd172, 8'd160, 8'd148, 8'd135, 8'd123, 8'd110, 8'd98,  8'd86,
      8'd75,  8'd63,  8'd53,  8'd43,  8'd34,  8'd26,  8'd19,  8'd13,
      8'd8,   8'd4,   8'd2,   8'd0,   8'd0,   8'd1,   8'd3,   8'd7,
      8'd11,  8'd17,  8'd24,  8'd32,  8'd41,  8'd50,  8'd60,  8'd71,
      8'd83,  8'd95,  8'd107, 8'd119, 8'd132, 8'd144, 8'd157, 8'd169,
      8'd180, 8'd191, 8'd202, 8'd212, 8'd221, 8'd229, 8'd236, 8'd242,
      8'd247, 8'd251, 8'd253, 8'd255, 8'd255, 8'd254, 8'd252, 8'd248
   };

   localparam logic [COLOR_W-1:0] BLUE_TAB [COLOR_COUNT] = '{
      8'd31,  8'd23,  8'd17,  8'd11,  8'd6,   8'd3,   8'd1,   8'd0,
      8'd0,   8'd2,   8'd5,   8'd8,   8'd14,  8'd20,  8'd27,  8'd35,
      8'd44,  8'd54,  8'd64,  8'd76,  8'd87,  8'd99,  8'd112, 8'd124,
      8'd137, 8'd149, 8'd161, 8'd173, 8'd185, 8'd195, 8'd206, 8'd215,
      8'd224, 8'd232, 8'd238, 8'd244, 8'd248, 8'd252, 8'd254, 8'd255,
      8'd255, 8'd253, 8'd250, 8'd247, 8'd242, 8'd235, 8'd228, 8'd220,
      8'd211, 8'd201, 8'd191, 8'd180, 8'd168, 8'd156, 8'd144, 8'd131,
      8'd119, 8'd106, 8'd94,  8'd82,  8'd71,  8'd60,  8'd49,  8'd40
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_SEND,
      ST_FLUSH
   } rbl_state_type;

   typedef struct packed {
      logic load_div;
      logic step_div;
      logic load_root;
      logic step_root;
   } rbl_ctrl_type;

   typedef struct packed {
      logic last_step;
   } rbl_stat_type;

endpackage

`default_nettype wire

// ----- src/rbl_channels.sv -----
// Interfaces: sample request channel and bar response channel.
`default_nettype none

interface rbl_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbl_pkg::SAMPLE_W-1:0] sample;
   logic                                frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface rbl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rbl_pkg::NUM_W-1:0]           bar_number;
   logic [rbl_pkg::HEIGHT_W-1:0]        bar_height;
   logic [rbl_pkg::COLOR_W-1:0]         green_level;
   logic [rbl_pkg::COLOR_W-1:0]         blue_level;
   logic                                last_bar;

   modport source (output valid, output bar_number, output bar_height, output green_level,
                   output blue_level, output last_bar, input ready);
   modport sink   (input valid, input bar_number, input bar_height, input green_level,
                   input blue_level, input last_bar, output ready);
endinterface

`default_nettype wire

// ----- src/rms_bar_level_meter_core.sv -----
// Top level: windowed RMS bar meter with sequencer, accumulator and response register.
//
// Usage: signed Q1.15 samples enter on req_chan, one beat per sample, frame_end on the
// last sample of a frame. Samples are grouped into 64 bars of csr_write_data samples each
// (0 acts as 1, above 1024 acts as 1024); write csr only while the block is idle.
// Each finished bar leaves on rsp_chan as one beat: number, Q1.14 height
// min(3.5*rms, 1.8), green and blue levels from fixed tables, last_bar on bar 63.
// Throughput: one sample at a time. A sample that does not close a bar is squared and
// accumulated; a sample that closes a bar then passes a divide load, 32 divide steps,
// a root load and 16 root steps on the one shared trial subtractor, and its beat is
// loaded into the response register before the next sample is taken.
// At frame end, unreached bars go out with height zero, one beat per cycle unless rsp_chan
// stalls; all accumulation state then clears. Samples past bar 63 drop until frame end.
// Reset clears the sums, counts and bar index, sets samples per bar to 1, empties
// the response register and holds req ready low while it is asserted. When the receiver
// stalls, the response register holds its beat; the block keeps taking samples and
// stalls only when it needs to load a new beat.
`default_nettype none

module rms_bar_level_meter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rbl_req_if.sink                             req_chan,
   rbl_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_write_enable,
   input  wire logic [rbl_pkg::CNT_W-1:0]      csr_write_data
);

   rbl_pkg::rbl_state_type state_ff, state_in;

   logic signed [rbl_pkg::SAMPLE_W-1:0] sample_ff;
   logic                                fend_ff;
   logic [rbl_pkg::SQ_W-1:0]            sq_ff;
   logic [rbl_pkg::SUM_W-1:0]           sum_ff;
   logic [rbl_pkg::CNT_W-1:0]           count_ff;
   logic [rbl_pkg::BAR_W-1:0]           bar_ff;
   logic [rbl_pkg::CNT_W-1:0]           spb_ff;

   logic                                rsp_valid_ff;
   logic [rbl_pkg::NUM_W-1:0]           rsp_number_ff;
   logic [rbl_pkg::HEIGHT_W-1:0]        rsp_height_ff;
   logic [rbl_pkg::COLOR_W-1:0]         rsp_green_ff;
   logic [rbl_pkg::COLOR_W-1:0]         rsp_blue_ff;
   logic                                rsp_last_ff;

   logic                                req_accept;
   logic                                slot_free;
   logic                                bar_open;
   logic                                bar_done;
   logic [rbl_pkg::CNT_W-1:0]           limit;
   logic [rbl_pkg::SUM_W:0]             sum_wide;
   logic [rbl_pkg::SUM_W-1:0]           sum_next;
   logic [rbl_pkg::CNT_W-1:0]           count_next;
   logic                                bar_full;
   logic signed [2*rbl_pkg::SAMPLE_W-1:0] product;
   logic [rbl_pkg::NUM_W-1:0]           color_idx;
   logic [rbl_pkg::HEIGHT_W-1:0]        calc_height;

   rbl_pkg::rbl_ctrl_type               ctrl;
   rbl_pkg::rbl_stat_type               stat;
   logic                                req_ready;
   logic                                load_rsp;
   logic                                load_send;
   logic                                clear_frame;

   // ---------------------------------------------------------------- bar arithmetic
   assign req_accept = req_chan.valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_chan.ready;
   assign bar_open   = (bar_ff < rbl_pkg::BAR_W'(rbl_pkg::BAR_COUNT));
   assign bar_done   = (bar_ff == rbl_pkg::BAR_W'(rbl_pkg::BAR_COUNT));

   // clamp the programmed bar length into its legal range
   always_comb begin
      if (spb_ff == '0) begin
         limit = rbl_pkg::CNT_W'(1);
      end else if (spb_ff > rbl_pkg::CNT_W'(rbl_pkg::MAX_SAMPLES_PER_BAR)) begin
         limit = rbl_pkg::CNT_W'(rbl_pkg::MAX_SAMPLES_PER_BAR);
      end else begin
         limit = spb_ff;
      end
   end

   assign product    = sample_ff * sample_ff;
   assign sum_wide   = {1'b0, sum_ff} + (rbl_pkg::SUM_W + 1)'(sq_ff);
   assign sum_next   = sum_wide[rbl_pkg::SUM_W] ? '1 : sum_wide[rbl_pkg::SUM_W-1:0];
   assign count_next = count_ff + 1'b1;
   // a lowered bar length closes the bar on its next sample
   assign bar_full   = (count_next >= limit);

   assign color_idx  = rbl_pkg::NUM_W'((32'(bar_ff) * rbl_pkg::COLOR_COUNT)
                                       / rbl_pkg::BAR_COUNT);

   rbl_root_path u_root_path (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sum    (sum_ff),
      .count  (count_ff),
      .stat   (stat),
      .height (calc_height)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbl_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (bar_open) begin
                  state_in = rbl_pkg::ST_SQUARE;
               end else if (req_chan.frame_end) begin
                  state_in = rbl_pkg::ST_FLUSH;
               end
            end
         end
         rbl_pkg::ST_SQUARE:    state_in = rbl_pkg::ST_ACCUM;
         rbl_pkg::ST_ACCUM: begin
            state_in = (bar_full || fend_ff) ? rbl_pkg::ST_DIV_LOAD : rbl_pkg::ST_IDLE;
         end
         rbl_pkg::ST_DIV_LOAD:  state_in = rbl_pkg::ST_DIV;
         rbl_pkg::ST_DIV: begin
            if (stat.last_step) begin
               state_in = rbl_pkg::ST_ROOT_LOAD;
            end
         end
         rbl_pkg::ST_ROOT_LOAD: state_in = rbl_pkg::ST_ROOT;
         rbl_pkg::ST_ROOT: begin
            if (stat.last_step) begin
               state_in = rbl_pkg::ST_SEND;
            end
         end
         rbl_pkg::ST_SEND: begin
            if (slot_free) begin
               state_in = fend_ff ? rbl_pkg::ST_FLUSH : rbl_pkg::ST_IDLE;
            end
         end
         rbl_pkg::ST_FLUSH: begin
            if (bar_done) begin
               state_in = rbl_pkg::ST_IDLE;
            end
         end
         default:               state_in = rbl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      ctrl           = '0;
      load_send      = 1'b0;
      load_rsp       = 1'b0;
      clear_frame    = 1'b0;
      case (state_ff)
         // take nothing while reset is held
         rbl_pkg::ST_IDLE:      req_ready      = !reset;
         rbl_pkg::ST_DIV_LOAD:  ctrl.load_div  = 1'b1;
         rbl_pkg::ST_DIV:       ctrl.step_div  = 1'b1;
         rbl_pkg::ST_ROOT_LOAD: ctrl.load_root = 1'b1;
         rbl_pkg::ST_ROOT:      ctrl.step_root = 1'b1;
         rbl_pkg::ST_SEND: begin
            load_send = slot_free;
            load_rsp  = slot_free;
         end
         rbl_pkg::ST_FLUSH: begin
            load_rsp    = slot_free && !bar_done;
            clear_frame = bar_done;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbl_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         bar_ff       <= '0;
         spb_ff       <= rbl_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            spb_ff <= csr_write_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == rbl_pkg::ST_ACCUM) begin
            sum_ff   <= sum_next;
            count_ff <= count_next;
         end
         // advance to the next bar once its beat is loaded
         if (load_send) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (load_rsp) begin
            bar_ff <= bar_ff + 1'b1;
         end else if (clear_frame) begin
            bar_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_chan.sample;
         fend_ff   <= req_chan.frame_end;
      end
      if (state_ff == rbl_pkg::ST_SQUARE) begin
         sq_ff <= product[rbl_pkg::SQ_W-1:0];
      end
      if (load_rsp) begin
         rsp_number_ff <= bar_ff[rbl_pkg::NUM_W-1:0];
         rsp_height_ff <= load_send ? calc_height : '0;
         rsp_green_ff  <= rbl_pkg::GREEN_TAB[color_idx];
         rsp_blue_ff   <= rbl_pkg::BLUE_TAB[color_idx];
         rsp_last_ff   <= (bar_ff == rbl_pkg::BAR_W'(rbl_pkg::BAR_COUNT - 1));
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.bar_number  = rsp_number_ff;
   assign rsp_chan.bar_height  = rsp_height_ff;
   assign rsp_chan.green_level = rsp_green_ff;
   assign rsp_chan.blue_level  = rsp_blue_ff;
   assign rsp_chan.last_bar    = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rbl_pkg::ST_DIV_LOAD) |-> ##33 (state_ff == rbl_pkg::ST_ROOT_LOAD))
      else $error("divide did not finish in its fixed step count");

   a_height_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_height_ff <= rbl_pkg::HEIGHT_MAX))
      else $error("bar height beyond clamp");

   a_bar_range: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> bar_open)
      else $error("beat loaded past the last bar");

endmodule

`default_nettype wire

// ----- src/rbl_trial_sub.sv -----
// Shared trial subtractor: difference and does-it-fit flag for divide and root steps.
`default_nettype none

module rbl_trial_sub (
   input  wire logic [rbl_pkg::UNIT_W-1:0] minuend,
   input  wire logic [rbl_pkg::UNIT_W-1:0] subtrahend,
   output logic      [rbl_pkg::UNIT_W-1:0] diff,
   output logic                            fits
);

   logic [rbl_pkg::UNIT_W:0] wide;

   assign wide = {1'b0, minuend} - {1'b0, subtrahend};
   assign diff = wide[rbl_pkg::UNIT_W-1:0];
   assign fits = ~wide[rbl_pkg::UNIT_W];

endmodule

`default_nettype wire

// ----- src/rbl_root_path.sv -----
// Height datapath: scale by 49/16, restoring divide by count, digit-by-digit square root.
`default_nettype none

module rbl_root_path (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rbl_pkg::rbl_ctrl_type              ctrl,
   input  wire logic [rbl_pkg::SUM_W-1:0]          sum,
   input  wire logic [rbl_pkg::CNT_W-1:0]          count,
   output rbl_pkg::rbl_stat_type                   stat,
   output logic      [rbl_pkg::HEIGHT_W-1:0]       height
);

   logic [rbl_pkg::QUO_W-1:0]    dvd_ff;
   logic [rbl_pkg::REM_W-1:0]    rem_ff;
   logic [rbl_pkg::ROOT_W-1:0]   root_ff;
   logic [rbl_pkg::CNT_W-1:0]    div_ff;
   logic [rbl_pkg::STEP_W-1:0]   step_ff;

   logic [rbl_pkg::SCALED_W-1:0] scaled;
   logic [rbl_pkg::DVD_W-1:0]    dvd_init;
   logic [rbl_pkg::UNIT_W-1:0]   op_a;
   logic [rbl_pkg::UNIT_W-1:0]   op_b;
   logic [rbl_pkg::UNIT_W-1:0]   diff;
   logic                         fits;
   logic [rbl_pkg::REM_W-1:0]    rem_in;

   // 49 * sum / 16, floor; dividing this by count equals floor(49*sum / (16*count))
   assign scaled   = ({6'd0, sum} << 5) + ({6'd0, sum} << 4) + {6'd0, sum};
   assign dvd_init = scaled[rbl_pkg::SCALED_W-1:4];

   always_comb begin
      if (ctrl.step_root) begin
         op_a = {rem_ff, dvd_ff[rbl_pkg::QUO_W-1 -: 2]};
         op_b = rbl_pkg::UNIT_W'({root_ff, 2'b01});
      end else begin
         op_a = rbl_pkg::UNIT_W'({rem_ff[rbl_pkg::CNT_W-1:0], dvd_ff[rbl_pkg::QUO_W-1]});
         op_b = rbl_pkg::UNIT_W'(div_ff);
      end
   end

   rbl_trial_sub u_trial_sub (
      .minuend    (op_a),
      .subtrahend (op_b),
      .diff       (diff),
      .fits       (fits)
   );

   // keep the trial result when it fits, else the shifted-in remainder
   assign rem_in = fits ? diff[rbl_pkg::REM_W-1:0] : op_a[rbl_pkg::REM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (ctrl.load_div) begin
         step_ff <= rbl_pkg::STEP_W'(rbl_pkg::DIV_STEPS - 1);
      end else if (ctrl.load_root) begin
         step_ff <= rbl_pkg::STEP_W'(rbl_pkg::ROOT_STEPS - 1);
      end else if (ctrl.step_div || ctrl.step_root) begin
         step_ff <= step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_div) begin
         // quotient fits 32 bits, so the top bits already sit below count
         rem_ff <= rbl_pkg::REM_W'(dvd_init[rbl_pkg::DVD_W-1:rbl_pkg::QUO_W]);
         dvd_ff <= dvd_init[rbl_pkg::QUO_W-1:0];
         div_ff <= count;
      end else if (ctrl.step_div) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[rbl_pkg::QUO_W-2:0], fits};
      end else if (ctrl.load_root) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctrl.step_root) begin
         rem_ff  <= rem_in;
         root_ff <= {root_ff[rbl_pkg::ROOT_W-2:0], fits};
         dvd_ff  <= dvd_ff << 2;
      end
   end

   assign stat.last_step = (step_ff == '0);
   assign height = (root_ff > {1'b0, rbl_pkg::HEIGHT_MAX}) ? rbl_pkg::HEIGHT_MAX
                                                           : root_ff[rbl_pkg::HEIGHT_W-1:0];

endmodule

`default_nettype wire
